// ----- design/scaler_ratio_calculator_unit_assert.svh -----
// Assertion macros shared by the scaler ratio calculator modules.
`ifndef SCALER_RATIO_CALCULATOR_UNIT_ASSERT_SVH
`define SCALER_RATIO_CALCULATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scu assertion failed");

// Next-cycle implication.
`define SCU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scu assertion failed");

`endif

// ----- design/scu_pkg.sv -----
package scu_pkg;

	localparam int LEN_W    = 12;
	localparam int VST_W    = 8;
	localparam int OP_W     = 2;
	localparam int PANEL_W  = 11;
	localparam int RATIO_W  = 16;
	localparam int DOWN_W   = 12;
	localparam int DE_W     = 10;

	localparam int NUM_W    = 26;
	localparam int DEN_W    = 16;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W    = $clog2(DIV_STEPS);

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 72;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LINE    = 2'd2;

	localparam logic [OP_W-1:0] OP_HORZ = 2'd0;
	localparam logic [OP_W-1:0] OP_VERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DE   = 2'd2;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_HUP  = 3'd1;
	localparam logic [2:0] KIND_HDN  = 3'd2;
	localparam logic [2:0] KIND_VERT = 3'd3;
	localparam logic [2:0] KIND_DE   = 3'd4;

	localparam logic [DOWN_W-1:0]  DOWN_UNITY = 12'h400;
	localparam logic [RATIO_W-1:0] UP_UNITY   = 16'h2000;
	localparam logic [RATIO_W-1:0] RATIO_MAX  = 16'hFFFF;
	localparam logic [RATIO_W-1:0] DOWN_MAX   = 16'd4095;
	localparam logic [RATIO_W-1:0] DE_MAX     = 16'd1023;

	localparam logic [PANEL_W-1:0] WIDTH_RESET  = 11'd800;
	localparam logic [PANEL_W-1:0] HEIGHT_RESET = 11'd480;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_sts_t;

endpackage

// ----- design/scaler_ratio_calculator_unit.sv -----
// Channel   Direction  Transaction carries
// s_axis    in         operation, length, vertical_start
// m_axis    out        down/up ratio, line buffer length, vertical ratio, DE, overflow
// cfg       in         register index and write data (panel width, height, half-line)
//
// From acceptance to result an item passes a setup step, the shared one-bit-per-cycle
// restoring divider, a step to leave the divide state and a step to saturate and
// register; the next item is taken only once the sequencer is back in idle.
// Operation 3 skips the divider.
// s_axis_tready is high only while the sequencer is idle; a stalled result waits in the
// output register while the next item is taken, and the sequencer holds only if a second
// result is ready before the first has gone.
// Reset is asynchronous, active low; it restores the config defaults and unity ratio.
`include "scaler_ratio_calculator_unit_assert.svh"

module scaler_ratio_calculator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// operation[1:0], length[13:2], vertical_start[21:14], zero fill
	input  logic [scu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// down_ratio[11:0], up_ratio[27:12], line_buffer_length[38:28],
	// vertical_ratio[54:39], vertical_de_position[64:55], overflow[65], zero fill
	output logic [scu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scu_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;

	logic [scu_pkg::PANEL_W-1:0] width_q;
	logic [scu_pkg::PANEL_W-1:0] height_q;
	logic                        half_q;
	logic [scu_pkg::RATIO_W-1:0] stored_q;

	logic [scu_pkg::OP_W-1:0]  op_q;
	logic [scu_pkg::LEN_W-1:0] len_q;
	logic [scu_pkg::VST_W-1:0] vst_q;
	logic [2:0]                kind_q;

	logic                          m_valid_q;
	logic [scu_pkg::OUT_TDATA_W-1:0] m_data_q;

	scu_pkg::div_req_t div_req;
	scu_pkg::div_sts_t div_sts;

	logic [2:0]                    kind_d;
	logic [scu_pkg::NUM_W-1:0]     num_d;
	logic [scu_pkg::DEN_W-1:0]     den_d;

	logic [scu_pkg::RATIO_W-1:0]   max_v;
	logic                          sat;
	logic [scu_pkg::RATIO_W-1:0]   val;
	logic [scu_pkg::DOWN_W-1:0]    f_down;
	logic [scu_pkg::RATIO_W-1:0]   f_up;
	logic [scu_pkg::PANEL_W-1:0]   f_lb;
	logic [scu_pkg::RATIO_W-1:0]   f_vr;
	logic [scu_pkg::DE_W-1:0]      f_de;
	logic                          f_ovf;
	logic                          out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= scu_pkg::WIDTH_RESET;
			height_q <= scu_pkg::HEIGHT_RESET;
			half_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				scu_pkg::REG_PANEL_WIDTH:  width_q  <= cfg_data;
				scu_pkg::REG_PANEL_HEIGHT: height_q <= cfg_data;
				scu_pkg::REG_HALF_LINE:    half_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Setup: pick numerator, divisor and result kind.
	always_comb begin
		kind_d = scu_pkg::KIND_NONE;
		num_d  = '0;
		den_d  = '0;
		case (op_q)
			scu_pkg::OP_HORZ: begin
				den_d = {5'b0, width_q};
				if ({1'b0, width_q} >= len_q) begin
					kind_d = scu_pkg::KIND_HUP;
					num_d  = {1'b0, len_q, 13'b0};
				end else begin
					kind_d = scu_pkg::KIND_HDN;
					num_d  = {4'b0, len_q, 10'b0};
				end
			end
			scu_pkg::OP_VERT: begin
				kind_d = scu_pkg::KIND_VERT;
				if (half_q && (len_q > {1'b0, height_q}) && (height_q != '0)) begin
					num_d = {len_q, 14'b0};
					den_d = {4'b0, height_q, 1'b0} - 16'd1;
				end else begin
					num_d = {1'b0, len_q, 13'b0};
					den_d = {5'b0, height_q};
				end
			end
			scu_pkg::OP_DE: begin
				kind_d = scu_pkg::KIND_DE;
				num_d  = {5'b0, vst_q, 13'b0};
				den_d  = stored_q;
			end
			default: ;
		endcase
	end

	assign div_req.start = (state_q == ST_SETUP) && (kind_d != scu_pkg::KIND_NONE);
	assign div_req.num   = num_d;
	assign div_req.den   = den_d;

	scu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// Saturate and format.
	always_comb begin
		case (kind_q)
			scu_pkg::KIND_HDN: max_v = scu_pkg::DOWN_MAX;
			scu_pkg::KIND_DE:  max_v = scu_pkg::DE_MAX;
			default:           max_v = scu_pkg::RATIO_MAX;
		endcase
		sat = (div_sts.quo > {10'b0, max_v});
		val = sat ? max_v : div_sts.quo[scu_pkg::RATIO_W-1:0];
		f_down = '0;
		f_up   = '0;
		f_lb   = '0;
		f_vr   = '0;
		f_de   = '0;
		f_ovf  = 1'b0;
		case (kind_q)
			scu_pkg::KIND_HUP: begin
				f_up   = val;
				f_down = scu_pkg::DOWN_UNITY;
				f_lb   = len_q[scu_pkg::PANEL_W-1:0];
				f_ovf  = sat;
			end
			scu_pkg::KIND_HDN: begin
				f_down = val[scu_pkg::DOWN_W-1:0];
				f_up   = scu_pkg::UP_UNITY;
				f_lb   = width_q;
				f_ovf  = sat;
			end
			scu_pkg::KIND_VERT: begin
				f_vr  = val;
				f_ovf = sat;
			end
			scu_pkg::KIND_DE: begin
				f_de  = val[scu_pkg::DE_W-1:0];
				f_ovf = sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			stored_q  <= scu_pkg::UP_UNITY;
			kind_q    <= scu_pkg::KIND_NONE;
		end else begin
			if ((state_q == ST_OUT) && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					kind_q  <= kind_d;
					state_q <= (kind_d == scu_pkg::KIND_NONE) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (kind_q == scu_pkg::KIND_VERT)
							stored_q <= f_vr;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q  <= s_axis_tdata[1:0];
			len_q <= s_axis_tdata[13:2];
			vst_q <= s_axis_tdata[21:14];
		end
		if ((state_q == ST_OUT) && out_free)
			m_data_q <= {6'b0, f_ovf, f_de, f_vr, f_lb, f_up, f_down};
	end

	`SCU_ASSERT_IMP(a_div_running, clk, arst_n, state_q == ST_DIV, div_sts.busy || div_sts.done)
	`SCU_ASSERT_IMP(a_done_in_div, clk, arst_n, div_sts.done, state_q == ST_DIV)
	`SCU_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

// ----- design/scu_div.sv -----
`include "scaler_ratio_calculator_unit_assert.svh"

module scu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  scu_pkg::div_req_t req,
	output scu_pkg::div_sts_t sts
);

	logic [scu_pkg::NUM_W-1:0] a_q;
	logic [scu_pkg::DEN_W-1:0] rem_q;
	logic [scu_pkg::DEN_W-1:0] den_q;
	logic [scu_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [scu_pkg::DEN_W:0] sh;
	logic [scu_pkg::DEN_W:0] diff;
	logic                    qbit;

	assign sh   = {rem_q, a_q[scu_pkg::NUM_W-1]};
	assign qbit = (sh >= {1'b0, den_q});
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= scu_pkg::CNT_W'(scu_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[scu_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[scu_pkg::DEN_W-1:0] : sh[scu_pkg::DEN_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quo  = a_q;

	`SCU_ASSERT_IMP(a_div_done_idle, clk, arst_n, done_q, !busy_q)
	`SCU_ASSERT_NXT(a_div_last_step, clk, arst_n, busy_q && !req.start && (cnt_q == '0), done_q)
	`SCU_ASSERT_IMP(a_div_no_restart, clk, arst_n, req.start, !busy_q)

endmodule

// ----- tb/scaler_ratio_calculator_unit_test.sv -----
`timescale 1ns / 100ps

module scaler_ratio_calculator_unit_test;

	localparam logic [scu_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int NUM_PHASES = 9;
	localparam int PHASE_ITEMS = 211;

	typedef struct packed {
		logic [scu_pkg::DOWN_W-1:0]  down;
		logic [scu_pkg::RATIO_W-1:0] up;
		logic [scu_pkg::PANEL_W-1:0] lb;
		logic [scu_pkg::RATIO_W-1:0] vr;
		logic [scu_pkg::DE_W-1:0]    de;
		logic                        ov;
	} ratio_res_t;

	typedef struct packed {
		logic [scu_pkg::OP_W-1:0]  op;
		logic [scu_pkg::LEN_W-1:0] len;
		logic [scu_pkg::VST_W-1:0] vst;
		logic                      typed;
		ratio_res_t                res;
	} stim_row_t;

	localparam int NUM_ROWS = 24;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [scu_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [scu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [scu_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [scu_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	scaler_ratio_calculator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [scu_pkg::PANEL_W-1:0] cur_width = scu_pkg::WIDTH_RESET;
	logic [scu_pkg::PANEL_W-1:0] cur_height = scu_pkg::HEIGHT_RESET;
	logic                        cur_half = 1'b1;
	logic [scu_pkg::RATIO_W-1:0] held_vratio = scu_pkg::UP_UNITY;

	ratio_res_t ratio_q[$];
	int         errors = 0;
	int         cycles = 0;
	int         src_idle_pct = 33;
	int         dst_idle_pct = 58;
	logic       hold_req = 1'b0;
	logic       hold_seen = 1'b0;
	int         hold_left = 0;

	stim_row_t dir_tab [NUM_ROWS] = '{
		'{scu_pkg::OP_DE,   12'd0,    8'd0,   1'b1, '{12'd0, 16'd0, 11'd0, 16'd0, 10'd0, 1'b0}},
		'{scu_pkg::OP_DE,   12'd0,    8'd255, 1'b1,
			'{12'd0, 16'd0, 11'd0, 16'd0, 10'd255, 1'b0}},
		'{scu_pkg::OP_HORZ, 12'd0,    8'd0,   1'b1,
			'{scu_pkg::DOWN_UNITY, 16'd0, 11'd0, 16'd0, 10'd0, 1'b0}},
		'{scu_pkg::OP_HORZ, 12'd800,  8'd0,   1'b1,
			'{scu_pkg::DOWN_UNITY, scu_pkg::UP_UNITY, 11'd800, 16'd0, 10'd0, 1'b0}},
		'{scu_pkg::OP_HORZ, 12'd4095, 8'd255, 1'b1,
			'{12'd4095, scu_pkg::UP_UNITY, 11'd800, 16'd0, 10'd0, 1'b1}},
		'{scu_pkg::OP_HORZ, 12'd801,  8'd0,   1'b0, '0},
		'{scu_pkg::OP_HORZ, 12'd1280, 8'd0,   1'b0, '0},
		'{OP_UNUSED,        12'd4095, 8'd255, 1'b1, '0},
		'{scu_pkg::OP_VERT, 12'd0,    8'd0,   1'b1, '0},
		'{scu_pkg::OP_DE,   12'd0,    8'd255, 1'b1,
			'{12'd0, 16'd0, 11'd0, 16'd0, 10'd1023, 1'b1}},
		'{scu_pkg::OP_DE,   12'd0,    8'd0,   1'b1,
			'{12'd0, 16'd0, 11'd0, 16'd0, 10'd1023, 1'b1}},
		'{scu_pkg::OP_VERT, 12'd480,  8'd0,   1'b1,
			'{12'd0, 16'd0, 11'd0, scu_pkg::UP_UNITY, 10'd0, 1'b0}},
		'{scu_pkg::OP_VERT, 12'd481,  8'd0,   1'b0, '0},
		'{scu_pkg::OP_VERT, 12'd4095, 8'd0,   1'b1,
			'{12'd0, 16'd0, 11'd0, scu_pkg::RATIO_MAX, 10'd0, 1'b1}},
		'{scu_pkg::OP_DE,   12'd0,    8'd255, 1'b0, '0},
		'{scu_pkg::OP_DE,   12'd4095, 8'd128, 1'b0, '0},
		'{scu_pkg::OP_VERT, 12'd240,  8'd0,   1'b0, '0},
		'{scu_pkg::OP_DE,   12'd0,    8'd255, 1'b0, '0},
		'{scu_pkg::OP_DE,   12'd0,    8'd200, 1'b0, '0},
		'{scu_pkg::OP_VERT, 12'd720,  8'd0,   1'b0, '0},
		'{scu_pkg::OP_HORZ, 12'd1,    8'd0,   1'b0, '0},
		'{scu_pkg::OP_HORZ, 12'd2048, 8'd0,   1'b0, '0},
		'{OP_UNUSED,        12'd0,    8'd0,   1'b1, '0},
		'{scu_pkg::OP_DE,   12'd0,    8'd1,   1'b0, '0}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [scu_pkg::RATIO_W-1:0] sat_quot(input longint unsigned num,
			input longint unsigned den, input logic [scu_pkg::RATIO_W-1:0] lim,
			inout logic flag);
		longint unsigned q;
		if (den == 0) begin
			flag = 1'b1;
			return lim;
		end
		q = num / den;
		if (q > lim) begin
			flag = 1'b1;
			return lim;
		end
		return q[scu_pkg::RATIO_W-1:0];
	endfunction

	function automatic ratio_res_t compute_ratios(input logic [scu_pkg::OP_W-1:0] op,
			input logic [scu_pkg::LEN_W-1:0] len, input logic [scu_pkg::VST_W-1:0] vst);
		ratio_res_t                  r;
		longint unsigned             l64;
		logic [scu_pkg::RATIO_W-1:0] q;
		r = '0;
		l64 = len;
		case (op)
			scu_pkg::OP_HORZ: begin
				if (cur_width >= len) begin
					r.up = sat_quot(l64 << 13, cur_width, scu_pkg::RATIO_MAX, r.ov);
					r.down = scu_pkg::DOWN_UNITY;
					r.lb = len[scu_pkg::PANEL_W-1:0];
				end else begin
					q = sat_quot(l64 << 10, cur_width, scu_pkg::DOWN_MAX, r.ov);
					r.down = q[scu_pkg::DOWN_W-1:0];
					r.up = scu_pkg::UP_UNITY;
					r.lb = cur_width;
				end
			end
			scu_pkg::OP_VERT: begin
				if (cur_height == 0) begin
					r.vr = scu_pkg::RATIO_MAX;
					r.ov = 1'b1;
				end else if (cur_half && len > cur_height) begin
					r.vr = sat_quot(l64 << 14, 2 * longint'(cur_height) - 1,
						scu_pkg::RATIO_MAX, r.ov);
				end else begin
					r.vr = sat_quot(l64 << 13, cur_height, scu_pkg::RATIO_MAX, r.ov);
				end
				held_vratio = r.vr;
			end
			scu_pkg::OP_DE: begin
				q = sat_quot(longint'(vst) << 13, held_vratio, scu_pkg::DE_MAX, r.ov);
				r.de = q[scu_pkg::DE_W-1:0];
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_result(input logic [scu_pkg::OUT_TDATA_W-1:0] tdata);
		ratio_res_t want;
		if (ratio_q.size() == 0) begin
			report_mismatch("result with nothing expected");
			return;
		end
		want = ratio_q.pop_front();
		if (tdata[11:0] !== want.down)
			report_mismatch($sformatf("down_ratio %0d, want %0d", tdata[11:0], want.down));
		if (tdata[27:12] !== want.up)
			report_mismatch($sformatf("up_ratio %0d, want %0d", tdata[27:12], want.up));
		if (tdata[38:28] !== want.lb)
			report_mismatch($sformatf("line_buffer_length %0d, want %0d",
				tdata[38:28], want.lb));
		if (tdata[54:39] !== want.vr)
			report_mismatch($sformatf("vertical_ratio %0d, want %0d", tdata[54:39], want.vr));
		if (tdata[64:55] !== want.de)
			report_mismatch($sformatf("vertical_de_position %0d, want %0d",
				tdata[64:55], want.de));
		if (tdata[65] !== want.ov)
			report_mismatch($sformatf("overflow %0b, want %0b", tdata[65], want.ov));
	endtask

	// drain results; hold off for a long stretch on request
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata);
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	task automatic push_item(input logic [scu_pkg::OP_W-1:0] op,
			input logic [scu_pkg::LEN_W-1:0] len, input logic [scu_pkg::VST_W-1:0] vst,
			input logic typed, input ratio_res_t want);
		ratio_res_t pred;
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, vst, len, op};
		do @(posedge clk); while (!s_axis_tready);
		pred = compute_ratios(op, len, vst);
		ratio_q.push_back(typed ? want : pred);
	endtask

	task automatic cfg_write(input logic [scu_pkg::CFG_IDX_W-1:0] idx,
			input logic [scu_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			scu_pkg::REG_PANEL_WIDTH:  cur_width = val;
			scu_pkg::REG_PANEL_HEIGHT: cur_height = val;
			scu_pkg::REG_HALF_LINE:    cur_half = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned phase_w [NUM_PHASES] = '{800, 2047, 1, 1920, 640, 0, 2047, 0, 1024};
		int unsigned phase_h [NUM_PHASES] = '{480, 2047, 1, 1080, 2047, 0, 1, 0, 768};
		int unsigned phase_hl [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0, 0};
		logic [scu_pkg::OP_W-1:0]    op;
		logic [scu_pkg::LEN_W-1:0]   len;
		logic [scu_pkg::VST_W-1:0]   vst;
		logic [scu_pkg::PANEL_W-1:0] ref_len;
		int                          pick;
		int                          tmp;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++)
			push_item(dir_tab[i].op, dir_tab[i].len, dir_tab[i].vst, dir_tab[i].typed,
				dir_tab[i].res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			s_axis_tvalid <= 1'b0;
			while (ratio_q.size() != 0) @(posedge clk);
			src_idle_pct = (p < 3) ? 33 : (p < 6) ? 58 : 0;
			dst_idle_pct = (p < 3) ? 58 : (p < 6) ? 33 : 0;
			if (p == 7) begin
				phase_w[p] = $urandom_range(1, 2047);
				phase_h[p] = $urandom_range(1, 2047);
				phase_hl[p] = $urandom_range(1);
			end
			cfg_write(scu_pkg::REG_PANEL_WIDTH, scu_pkg::CFG_DATA_W'(phase_w[p]));
			cfg_write(scu_pkg::REG_PANEL_HEIGHT, scu_pkg::CFG_DATA_W'(phase_h[p]));
			cfg_write(scu_pkg::REG_HALF_LINE, scu_pkg::CFG_DATA_W'(phase_hl[p]));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(99);
				op = (pick < 30) ? scu_pkg::OP_HORZ :
					(pick < 62) ? scu_pkg::OP_VERT :
					(pick < 92) ? scu_pkg::OP_DE : OP_UNUSED;
				ref_len = (op == scu_pkg::OP_HORZ) ? cur_width : cur_height;
				case ($urandom_range(3))
					0: len = scu_pkg::LEN_W'($urandom_range(4095));
					1: begin
						tmp = int'(ref_len) + int'($urandom_range(8)) - 4;
						len = (tmp < 0) ? 12'd0 : scu_pkg::LEN_W'(tmp);
					end
					2: len = scu_pkg::LEN_W'($urandom_range(ref_len));
					default: len = $urandom_range(1) ? 12'd4095 : 12'd0;
				endcase
				vst = scu_pkg::VST_W'($urandom_range(255));
				push_item(op, len, vst, 1'b0, '0);
				if (p == NUM_PHASES - 1 && i == 40)
					hold_req <= ~hold_req;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (ratio_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
